// ===== hdl/rgbhsv_pkg.sv =====
// Shared types and constants for the RGB to HSV converter.
package rgbhsv_pkg;

  // Field widths
  localparam int unsigned ChanW  = 8;
  localparam int unsigned HueW   = 15;
  localparam int unsigned SatW   = 13;
  // Divider widths: dividend, quotient bits (one per cell), pre-shifted divisor
  localparam int unsigned NumW   = 23;
  localparam int unsigned QuoW   = 15;
  localparam int unsigned DenShW = ChanW + QuoW - 1;
  // Branch offset term width (t ranges to just under 5*255 in the blue branch)
  localparam int unsigned TermW  = 11;

  // Fixed-point constants: sixty degrees and a full turn, times 64
  localparam logic [NumW-1:0] HueSixty = NumW'(3840);
  localparam logic [HueW-1:0] HueFull  = HueW'(23040);
  // Saturation scale shift (times 4096)
  localparam int unsigned SatShift = 12;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [SatW-1:0]  saturation;
    logic [ChanW-1:0] brightness;
  } hsv_t;

  // Data moving down the divider chain: two quotients are built in lockstep
  typedef struct packed {
    logic              vld;
    logic              neg;
    logic [ChanW-1:0]  mx;
    logic [NumW-1:0]   hrem;
    logic [DenShW-1:0] hden;
    logic [QuoW-1:0]   hquo;
    logic [NumW-1:0]   srem;
    logic [DenShW-1:0] sden;
    logic [QuoW-1:0]   squo;
  } cell_t;

endpackage

// ===== hdl/rgbhsv_front.sv =====
// Input stage: finds max/min, picks the hue branch and forms both dividends.
module rgbhsv_front import rgbhsv_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  pixel_t pixel,
  output cell_t  cell_out
);

  logic [ChanW-1:0] r, g, b, mx, mn, d;
  logic [TermW-1:0] term;
  logic             neg;
  logic [ChanW-1:0] hden, sden;
  cell_t            stage_next;
  cell_t            stage;

  assign r = pixel.red;
  assign g = pixel.green;
  assign b = pixel.blue;

  // Find the extremes
  always_comb begin
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
  end

  // Pick the branch; red wins ties over green, green over blue
  always_comb begin
    neg  = 1'b0;
    term = '0;
    if (mx == r) begin
      if (g < b) begin
        neg  = 1'b1;
        term = TermW'(b - g);
      end else begin
        term = TermW'(g - b);
      end
    end else if (mx == g) begin
      term = TermW'(b) + (TermW'(d) << 1) - TermW'(r);
    end else begin
      term = TermW'(r) + (TermW'(d) << 2) - TermW'(g);
    end
  end

  // Guard zero divisors; the dividend is zero in those cases
  assign hden = (d == '0) ? ChanW'(1) : d;
  assign sden = (mx == '0) ? ChanW'(1) : mx;

  always_comb begin
    stage_next      = '0;
    stage_next.vld  = start;
    stage_next.neg  = neg;
    stage_next.mx   = mx;
    stage_next.hrem = NumW'(term) * HueSixty;
    stage_next.hden = DenShW'(hden) << (QuoW - 1);
    stage_next.hquo = '0;
    stage_next.srem = NumW'(d) << SatShift;
    stage_next.sden = DenShW'(sden) << (QuoW - 1);
    stage_next.squo = '0;
  end

  // Register the item
  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
    end else begin
      stage <= stage_next;
    end
  end

  assign cell_out = stage;

endmodule

// ===== hdl/rgbhsv_cell.sv =====
// One restoring-division cell: settles one quotient bit of each divider.
module rgbhsv_cell import rgbhsv_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cell_t cell_in,
  output cell_t cell_out
);

  logic  hge, sge;
  cell_t stage_next;
  cell_t stage;

  // Trial subtract against the divisor aligned to this bit
  assign hge = cell_in.hrem >= NumW'(cell_in.hden);
  assign sge = cell_in.srem >= NumW'(cell_in.sden);

  always_comb begin
    stage_next      = cell_in;
    stage_next.hrem = hge ? cell_in.hrem - NumW'(cell_in.hden) : cell_in.hrem;
    stage_next.srem = sge ? cell_in.srem - NumW'(cell_in.sden) : cell_in.srem;
    stage_next.hquo = {cell_in.hquo[QuoW-2:0], hge};
    stage_next.squo = {cell_in.squo[QuoW-2:0], sge};
    stage_next.hden = cell_in.hden >> 1;
    stage_next.sden = cell_in.sden >> 1;
  end

  // Advance to the neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
    end else begin
      stage <= stage_next;
    end
  end

  assign cell_out = stage;

endmodule

// ===== hdl/rgbhsv_back.sv =====
// Output stage: wraps negative hue and registers the result strobe.
module rgbhsv_back import rgbhsv_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cell_t cell_in,
  output logic  done,
  output hsv_t  result
);

  logic [HueW-1:0] q;
  hsv_t            res_next;
  hsv_t            res;
  logic            vld;

  assign q = cell_in.hquo;

  // Wrap a negative red-branch hue into one turn
  always_comb begin
    res_next.hue        = (cell_in.neg && (q != '0)) ? HueFull - q : q;
    res_next.saturation = cell_in.squo[SatW-1:0];
    res_next.brightness = cell_in.mx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= cell_in.vld;
    end
  end

  // Hold payload for the strobe cycle
  always_ff @(posedge clk) begin
    res <= res_next;
  end

  assign done   = vld;
  assign result = res;

endmodule

// ===== hdl/rgb_to_hsv_convert_top.sv =====
// RGB to HSV converter: front stage, chain of division cells, output stage.
// Done and result pass 17 registers: 1 front, 15 cells, 1 back; the front loads
// at the accepting edge itself.
// Throughput: one item per clock; busy is always low, every cycle may accept.
// Each quotient bit is settled by its own cell, so the chain length sets latency.
// Reset (rst, synchronous) clears all valid flags; no result strobes follow it.
module rgb_to_hsv_convert_top import rgbhsv_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  output logic   busy,
  input  pixel_t pixel,
  output logic   done,
  output hsv_t   result
);

  cell_t chain [QuoW+1];

  assign busy = 1'b0;

  rgbhsv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .pixel    (pixel),
    .cell_out (chain[0])
  );

  // Build the divider chain, one cell per quotient bit
  for (genvar i = 0; i < QuoW; i++) begin : g_cell
    rgbhsv_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_in  (chain[i]),
      .cell_out (chain[i+1])
    );
  end

  rgbhsv_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cell_in (chain[QuoW]),
    .done    (done),
    .result  (result)
  );

endmodule

// ===== dv/rgb_to_hsv_convert_top_tb.sv =====
// Self-checking testbench for the RGB to HSV converter top level.
module rgb_to_hsv_convert_top_tb import rgbhsv_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Latency    = 17;
  localparam int unsigned StallLimit = 2000;

  typedef struct {
    pixel_t px;
    hsv_t   hsv;
  } hsv_expect_t;

  logic   clk;
  logic   rst;
  logic   start;
  logic   busy;
  pixel_t pixel;
  logic   done;
  hsv_t   result;

  hsv_expect_t pending_hsv[$];
  int          error_count;
  int          idle_pct;
  int          quiet_cycles;

  rgb_to_hsv_convert_top dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .pixel  (pixel),
    .done   (done),
    .result (result)
  );

  // Free-running clock, 8 ns period
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Compute hue, saturation and value of one pixel
  function automatic hsv_t predict_hsv(pixel_t p);
    int   r, g, b, mx, mn, d, h, s;
    hsv_t o;
    r  = int'(p.red);
    g  = int'(p.green);
    b  = int'(p.blue);
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    h = 0;
    s = 0;
    // Red wins ties over green, green over blue
    if (d != 0) begin
      if (mx == r) h = (3840 * (g - b)) / d;
      else if (mx == g) h = (3840 * (b - r) + 7680 * d) / d;
      else h = (3840 * (r - g) + 15360 * d) / d;
      if (h < 0) h = h + 23040;
    end
    if (mx != 0) s = (d * 4096) / mx;
    o.hue        = HueW'(h);
    o.saturation = SatW'(s);
    o.brightness = ChanW'(mx);
    return o;
  endfunction

  task automatic report_mismatch(string what, pixel_t p, int got, int want);
    $display("%0t: %s mismatch for rgb %0d,%0d,%0d: got %0d, expected %0d",
             $realtime, what, p.red, p.green, p.blue, got, want);
    error_count++;
  endtask

  // Check each result against the oldest expectation, then record accepted items
  always @(posedge clk) begin
    hsv_expect_t want;
    if (!rst) begin
      if (done) begin
        if (pending_hsv.size() == 0) begin
          report_mismatch("unexpected result", '0, result.hue, 0);
        end else begin
          want = pending_hsv.pop_front();
          if (result.hue !== want.hsv.hue)
            report_mismatch("hue", want.px, result.hue, want.hsv.hue);
          if (result.saturation !== want.hsv.saturation)
            report_mismatch("saturation", want.px, result.saturation,
                            want.hsv.saturation);
          if (result.brightness !== want.hsv.brightness)
            report_mismatch("brightness", want.px, result.brightness,
                            want.hsv.brightness);
        end
      end
      if (start && !busy) begin
        want.px  = pixel;
        want.hsv = predict_hsv(pixel);
        pending_hsv.push_back(want);
      end
      // Watchdog on cycles where nothing moves
      if (done || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("rgb_to_hsv_convert_top test failed");
        $finish;
      end
    end
  end

  // Send one item; entered and left at a falling edge, start stays high
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start       <= 1'b1;
    pixel.red   <= r;
    pixel.green <= g;
    pixel.blue  <= b;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic test_directed_corners();
    send_pixel(8'd0, 8'd0, 8'd0);       // black
    send_pixel(8'd255, 8'd255, 8'd255); // white
    send_pixel(8'd128, 8'd128, 8'd128); // gray
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd0);     // primaries
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);   // two-way ties on the max
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd1);     // red branch with negative hue
    send_pixel(8'd255, 8'd1, 8'd0);
    send_pixel(8'd1, 8'd0, 8'd0);       // smallest nonzero max
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd255, 8'd254, 8'd254); // smallest delta at top
    send_pixel(8'd254, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd254, 8'd255);
    send_pixel(8'd254, 8'd0, 8'd255);   // largest blue-branch term
    send_pixel(8'd200, 8'd100, 8'd50);
    send_pixel(8'd50, 8'd100, 8'd200);
    send_pixel(8'd170, 8'd85, 8'd255);
  endtask

  // Mostly uniform pixels, with grays, ties and extremes mixed in
  task automatic test_random_pixels(int count);
    logic [7:0] a, c, e;
    for (int i = 0; i < count; i++) begin
      a = 8'($urandom);
      c = 8'($urandom);
      e = 8'($urandom);
      case ($urandom_range(9))
        0: send_pixel(a, a, a);
        1: send_pixel(a, a, e);
        2: send_pixel(a, c, a);
        3: send_pixel(a, c, c);
        4: send_pixel($urandom_range(1) ? 8'd255 : 8'd0, c,
                      $urandom_range(1) ? 8'd255 : 8'd0);
        default: send_pixel(a, c, e);
      endcase
    end
  endtask

  // Two or three channels sharing the max, in every position
  task automatic test_tied_channels(int count);
    logic [7:0] hi, lo;
    for (int i = 0; i < count; i++) begin
      hi = 8'($urandom_range(255, 1));
      lo = 8'($urandom_range(hi - 1, 0));
      case ($urandom_range(3))
        0: send_pixel(hi, hi, lo);
        1: send_pixel(hi, lo, hi);
        2: send_pixel(lo, hi, hi);
        default: send_pixel(hi, hi, hi);
      endcase
    end
  endtask

  // Channels close together: small delta stresses the quotient rounding
  task automatic test_narrow_spread(int count);
    int base;
    int ch[3];
    for (int i = 0; i < count; i++) begin
      base = $urandom_range(255);
      for (int k = 0; k < 3; k++) begin
        ch[k] = base + $urandom_range(6) - 3;
        if (ch[k] < 0) ch[k] = 0;
        if (ch[k] > 255) ch[k] = 255;
      end
      send_pixel(8'(ch[0]), 8'(ch[1]), 8'(ch[2]));
    end
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    pixel        = '0;
    error_count  = 0;
    idle_pct     = 0;
    quiet_cycles = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Back-to-back items
    idle_pct = 0;
    test_directed_corners();
    test_random_pixels(350);
    // Sender mostly idle
    idle_pct = 80;
    test_random_pixels(350);
    test_tied_channels(100);
    // Sender idle part of the time
    idle_pct = 38;
    test_random_pixels(350);
    test_narrow_spread(100);
    // Finish with a full-rate stretch
    idle_pct = 0;
    test_random_pixels(200);
    start <= 1'b0;

    // Drain the pipeline, then allow for stray results
    while (pending_hsv.size() != 0) @(posedge clk);
    repeat (Latency + 8) @(posedge clk);
    if (pending_hsv.size() != 0)
      report_mismatch("missing results", pending_hsv[0].px, pending_hsv.size(), 0);

    if (error_count == 0) begin
      $display("rgb_to_hsv_convert_top test passed");
    end else begin
      $display("rgb_to_hsv_convert_top test failed");
    end
    $finish;
  end

endmodule
